// ===== src/polygon_zone_cost_marker_macros.svh =====
// ----------------------------------------------------------------------------
// Polygon zone cost marker assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef POLYGON_ZONE_COST_MARKER_MACROS_SVH
`define POLYGON_ZONE_COST_MARKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PZCM_ASSERT_IMP(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PZCM_ASSERT_NXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pzcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Polygon zone cost marker package
// Shared widths, codes and types of the zone marker and its edge lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pzcm_pkg;

  // Coordinates are signed Q15.16, so differences take one more bit and the
  // cross products take twice that.
  localparam int COORD_BITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  localparam int VIDX_W     = 4;
  localparam int VCOUNT_W   = 5;
  localparam int COST_W     = 8;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int MIN_POLY         = 3;

  localparam logic [COST_W-1:0] ZONE_COST = 8'd180;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = VCOUNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd1;

  // Control handed from the top level to each edge lane.
  typedef struct packed {
    logic adv;     // whole pipeline moves one stage
    logic active;  // this edge is part of the loaded polygon
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== src/pzcm_edge_lane.sv =====
// ----------------------------------------------------------------------------
// Polygon zone cost marker edge lane
// Three-stage crossing test of one polygon edge against the cell position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pzcm_edge_lane (
  input  logic                                   clk,
  input  pzcm_pkg::lane_ctl_t                    ctl,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] px,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] py,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] xi,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] yi,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] xj,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] yj,
  output logic                                   toggle
);
  import pzcm_pkg::*;

  logic signed [DIFF_BITS-1:0] tx_next;
  logic signed [DIFF_BITS-1:0] ty_next;
  logic signed [DIFF_BITS-1:0] dx_next;
  logic signed [DIFF_BITS-1:0] dy_next;
  logic                        cross_next;

  logic signed [DIFF_BITS-1:0] tx;
  logic signed [DIFF_BITS-1:0] ty;
  logic signed [DIFF_BITS-1:0] dx;
  logic signed [DIFF_BITS-1:0] dy;
  logic                        cross1;

  logic signed [PROD_BITS-1:0] p_lhs;
  logic signed [PROD_BITS-1:0] p_rhs;
  logic                        cross2;
  logic                        dy_neg2;

  always_comb begin
    tx_next    = $signed({px[COORD_BITS-1], px}) - $signed({xi[COORD_BITS-1], xi});
    ty_next    = $signed({py[COORD_BITS-1], py}) - $signed({yi[COORD_BITS-1], yi});
    dx_next    = $signed({xj[COORD_BITS-1], xj}) - $signed({xi[COORD_BITS-1], xi});
    dy_next    = $signed({yj[COORD_BITS-1], yj}) - $signed({yi[COORD_BITS-1], yi});
    cross_next = ctl.active && ((yi > py) != (yj > py));
  end

  // Stage one: differences and the straddle test.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      tx     <= tx_next;
      ty     <= ty_next;
      dx     <= dx_next;
      dy     <= dy_next;
      cross1 <= cross_next;
    end
  end

  // Stage two: both cross products at full width.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      p_lhs   <= tx * dy;
      p_rhs   <= dx * ty;
      cross2  <= cross1;
      dy_neg2 <= dy[DIFF_BITS-1];
    end
  end

  // Stage three: a downward edge flips the sense of the comparison.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      toggle <= cross2 && (dy_neg2 ? (p_lhs > p_rhs) : (p_lhs < p_rhs));
    end
  end

endmodule

`default_nettype wire

// ===== src/polygon_zone_cost_marker.sv =====
// ----------------------------------------------------------------------------
// Polygon zone cost marker
// Even-odd point-in-polygon test that raises the cost of cells in a zone.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while in_stall is low, and
// returns the result of a test item through five register stages (input,
// differences, products, edge decisions, output). Every polygon edge has
// its own lane with two 33 by 33 bit signed multipliers, so all edges of a
// cell are tested side by side in one pass. A write item stores one
// vertex on the edge where it is accepted and produces no result; a test
// item accepted on the next edge already sees it. When the output register
// holds a result that is being stalled, the whole pipeline stops and
// in_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module polygon_zone_cost_marker #(
  parameter int MAX_VERTICES = pzcm_pkg::DEF_MAX_VERTICES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Item input channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   func,
  input  logic [pzcm_pkg::VIDX_W-1:0]            vertex_index,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [pzcm_pkg::COORD_BITS-1:0] pos_y,
  input  logic [pzcm_pkg::COST_W-1:0]            cell_cost,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [pzcm_pkg::COST_W-1:0]            new_cost,
  output logic                                   inside_res,
  output logic                                   marked,
  // Register write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pzcm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pzcm_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pzcm_pkg::*;

  // Only slots that the vertex index can address ever hold a vertex, so the
  // table and the lane count stop there.
  localparam int TABLE_DEPTH = (MAX_VERTICES < (2 ** VIDX_W)) ? MAX_VERTICES : (2 ** VIDX_W);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int NCNT_W      = $clog2(TABLE_DEPTH + 1);

  // Configuration registers. The port never pushes back.
  logic                enable;
  logic [VCOUNT_W-1:0] vertex_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b1;
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:       enable       <= cfg_data[0];
        REG_VERTEX_COUNT: vertex_count <= cfg_data[VCOUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Pipeline control. Every stage moves together whenever the output
  // register is empty or its result is being taken.
  logic adv;
  logic in_acc;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && !in_stall;

  // Vertex table. Each lane reads its own slots; only the closing edge
  // reads a slot chosen by the vertex count.
  logic signed [COORD_BITS-1:0] vx [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] vy [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (in_acc && (func == FUNC_WRITE) && (int'(vertex_index) < TABLE_DEPTH)) begin
      vx[vertex_index[IDX_W-1:0]] <= pos_x;
      vy[vertex_index[IDX_W-1:0]] <= pos_y;
    end
  end

  // A vertex count above the table is treated as the whole table. The zone
  // is live only when enabled and at least a triangle is loaded.
  logic [NCNT_W-1:0] n_clamp;
  logic              zone_next;

  always_comb begin
    if (int'(vertex_count) > TABLE_DEPTH) begin
      n_clamp = NCNT_W'(TABLE_DEPTH);
    end else begin
      n_clamp = NCNT_W'(vertex_count);
    end
    zone_next = enable && (int'(vertex_count) >= MIN_POLY);
  end

  // Input stage: test items only; write items leave no trace here.
  logic                         s0_valid;
  logic signed [COORD_BITS-1:0] s0_px;
  logic signed [COORD_BITS-1:0] s0_py;
  logic [COST_W-1:0]            s0_old;
  logic                         s0_zone;
  logic [NCNT_W-1:0]            s0_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid && (func == FUNC_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_px   <= pos_x;
      s0_py   <= pos_y;
      s0_old  <= cell_cost;
      s0_zone <= zone_next;
      s0_n    <= n_clamp;
    end
  end

  // The closing edge joins the last loaded vertex back to slot zero. With
  // the zone off no lane is active, so the slot read does not matter.
  logic [IDX_W-1:0] last_idx;

  assign last_idx = s0_zone ? IDX_W'(s0_n - NCNT_W'(1)) : '0;

  // One lane per edge. Lane i tests the edge from vertex i to the vertex
  // before it; lane zero takes the closing edge.
  logic [TABLE_DEPTH-1:0] toggles;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_lane
    lane_ctl_t                    ctl;
    logic signed [COORD_BITS-1:0] xj;
    logic signed [COORD_BITS-1:0] yj;

    assign ctl.adv    = adv;
    assign ctl.active = s0_zone && (s0_n > NCNT_W'(i));

    if (i == 0) begin : g_close
      assign xj = vx[last_idx];
      assign yj = vy[last_idx];
    end else begin : g_chain
      assign xj = vx[i-1];
      assign yj = vy[i-1];
    end

    pzcm_edge_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .px     (s0_px),
      .py     (s0_py),
      .xi     (vx[i]),
      .yi     (vy[i]),
      .xj     (xj),
      .yj     (yj),
      .toggle (toggles[i])
    );
  end

  // Valid bits and cost travel beside the lanes for their three stages.
  logic [2:0]        sv_valid;
  logic [COST_W-1:0] s1_old;
  logic [COST_W-1:0] s2_old;
  logic [COST_W-1:0] s3_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv_valid <= '0;
    end else if (adv) begin
      sv_valid <= {sv_valid[1:0], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_old <= s0_old;
      s2_old <= s1_old;
      s3_old <= s2_old;
    end
  end

  // Output stage: an odd number of crossings puts the cell inside, and an
  // inside cell is raised to the zone cost unless it is already higher.
  logic inside_next;
  logic mark_next;

  always_comb begin
    inside_next = ^toggles;
    mark_next   = inside_next && (s3_old < ZONE_COST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_cost   <= mark_next ? ZONE_COST : s3_old;
      inside_res <= inside_next;
      marked     <= mark_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/pzcm_checker.sv =====
// ----------------------------------------------------------------------------
// Polygon zone cost marker port checker
// Watches the result port for results that contradict each other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_zone_cost_marker_macros.svh"

module pzcm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pzcm_pkg::COST_W-1:0]   new_cost,
  input logic                          inside_res,
  input logic                          marked
);
  import pzcm_pkg::*;

  `PZCM_ASSERT_IMP(a_mark_cost, clk, rst, out_valid && marked, new_cost == ZONE_COST, "marked cell without zone cost")
  `PZCM_ASSERT_IMP(a_mark_inside, clk, rst, out_valid && marked, inside_res, "marked cell outside the zone")
  `PZCM_ASSERT_IMP(a_inside_floor, clk, rst, out_valid && inside_res, new_cost >= ZONE_COST, "inside cell below zone cost")
  `PZCM_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(new_cost) && $stable(inside_res) && $stable(marked), "stalled result changed")

endmodule

bind polygon_zone_cost_marker pzcm_checker u_pzcm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .new_cost   (new_cost),
  .inside_res (inside_res),
  .marked     (marked)
);

`default_nettype wire
